FILE: src/mbcer_pkg.sv
`default_nettype none

package mbcer_pkg;

  localparam int WordBits = 32;
  localparam int IdxBits  = $clog2(WordBits);
  localparam int CntBits  = IdxBits + 1;

  typedef enum logic [2:0] {
    CmdCompress = 3'd0,
    CmdExpand   = 3'd1,
    CmdRotate   = 3'd2,
    CmdPopcount = 3'd3,
    CmdHighBit  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [WordBits-1:0] operand;
    logic [WordBits-1:0] mask;
  } req_t;

  typedef struct packed {
    logic [WordBits-1:0] result;
    logic                none_set;
  } rsp_t;

endpackage

`default_nettype wire

FILE: src/masked_bit_compress_expand_rotate.sv
`default_nettype none

// Masked bit compress, expand, rotate, popcount and highest-set-bit unit on
// 32-bit words. Every input word gives exactly one result word, after passing
// the input register, then the result register, and a new word is taken in
// every cycle while the result side keeps up; the result register
// together with the input register lets one more word enter while a result
// waits under stall. The per-bit mask ranks come from a five-level prefix
// scan, which sets the logic depth between the two registers.

module masked_bit_compress_expand_rotate (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire mbcer_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mbcer_pkg::rsp_t    out_data_o
);

  localparam int W  = mbcer_pkg::WordBits;
  localparam int IB = mbcer_pkg::IdxBits;
  localparam int CB = mbcer_pkg::CntBits;

  logic            req_valid_q, req_valid_d;
  mbcer_pkg::req_t req_q;
  logic            rsp_valid_q, rsp_valid_d;
  mbcer_pkg::rsp_t rsp_q, rsp_d;
  logic            out_ready;
  logic            req_move;
  logic            in_take;

  assign out_ready   = !rsp_valid_q || !out_stall_i;
  assign req_move    = req_valid_q && out_ready;
  assign in_stall_o  = req_valid_q && !out_ready;
  assign in_take     = in_valid_i && !in_stall_o;
  assign req_valid_d = in_take || (req_valid_q && !out_ready);
  assign rsp_valid_d = req_move || (rsp_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_data_i;
    end
    if (req_move) begin
      rsp_q <= rsp_d;
    end
  end

  // Prefix scans: masked-bit counts and the value of the nearest masked bit.
  logic [CB-1:0] cnt_lvl [IB+1][W];
  logic          has_lvl [IB+1][W];
  logic          val_lvl [IB+1][W];
  logic [CB-1:0] rank [W];

  always_comb begin
    for (int b = 0; b < W; b++) begin
      cnt_lvl[0][b] = {{(CB-1){1'b0}}, req_q.mask[b]};
      has_lvl[0][b] = req_q.mask[b];
      val_lvl[0][b] = req_q.mask[b] & req_q.operand[b];
    end
    for (int l = 0; l < IB; l++) begin
      for (int b = 0; b < W; b++) begin
        if (b >= (1 << l)) begin
          cnt_lvl[l+1][b] = cnt_lvl[l][b] + cnt_lvl[l][b-(1<<l)];
          has_lvl[l+1][b] = has_lvl[l][b] | has_lvl[l][b-(1<<l)];
          val_lvl[l+1][b] = has_lvl[l][b] ? val_lvl[l][b] : val_lvl[l][b-(1<<l)];
        end else begin
          cnt_lvl[l+1][b] = cnt_lvl[l][b];
          has_lvl[l+1][b] = has_lvl[l][b];
          val_lvl[l+1][b] = val_lvl[l][b];
        end
      end
    end
    for (int b = 0; b < W; b++) begin
      rank[b] = cnt_lvl[IB][b] - {{(CB-1){1'b0}}, req_q.mask[b]};
    end
  end

  logic [W-1:0]  comp_res;
  logic [W-1:0]  exp_res;
  logic [W-1:0]  rot_res;
  logic          rot_top;
  logic [IB-1:0] hb_idx;
  logic [W-1:0]  hb_x;

  always_comb begin
    comp_res = '0;
    for (int k = 0; k < W; k++) begin
      for (int b = 0; b < W; b++) begin
        if (req_q.mask[b] && req_q.operand[b] && (rank[b] == CB'(k))) begin
          comp_res[k] = 1'b1;
        end
      end
    end
  end

  assign rot_top = val_lvl[IB][W-1];

  always_comb begin
    for (int b = 0; b < W; b++) begin
      exp_res[b] = req_q.mask[b] & req_q.operand[rank[b][IB-1:0]];
      if (b == 0) begin
        rot_res[b] = req_q.mask[b] & rot_top;
      end else begin
        rot_res[b] = req_q.mask[b] &
                     (has_lvl[IB][b-1] ? val_lvl[IB][b-1] : rot_top);
      end
    end
  end

  always_comb begin
    hb_idx = '0;
    hb_x   = req_q.operand;
    for (int i = IB - 1; i >= 0; i--) begin
      if ((hb_x >> (1 << i)) != '0) begin
        hb_idx[i] = 1'b1;
        hb_x      = hb_x >> (1 << i);
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    case (mbcer_pkg::cmd_e'(req_q.cmd))
      mbcer_pkg::CmdCompress: rsp_d.result = comp_res;
      mbcer_pkg::CmdExpand:   rsp_d.result = exp_res;
      mbcer_pkg::CmdRotate:   rsp_d.result = rot_res;
      mbcer_pkg::CmdPopcount: rsp_d.result = W'(cnt_lvl[IB][W-1]);
      mbcer_pkg::CmdHighBit: begin
        rsp_d.result   = W'(hb_idx);
        rsp_d.none_set = (req_q.operand == '0);
      end
      default: rsp_d = '0;
    endcase
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

endmodule

`default_nettype wire

FILE: src/mbcer_checker.sv
`default_nettype none

module mbcer_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire mbcer_pkg::req_t in_data_i,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire mbcer_pkg::rsp_t out_data_o
);

  // A result word held under stall stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // The input side only stalls because the result side is backed up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without result backpressure");

  // A zero operand flag always comes with a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_set |-> out_data_o.result == '0)
    else $error("none_set with nonzero result");

  // With the result register empty, the input side is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

bind masked_bit_compress_expand_rotate mbcer_checker u_mbcer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
